// ===== hdl/ise_pkg.sv =====
`timescale 1ns / 1ps

package ise_pkg;

    localparam int ISE_MAX_ITEMS = 32;
    localparam int ISE_DATA_W    = 32;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic                         insert_en;
        logic                         shift_en;
        logic signed [ISE_DATA_W-1:0] new_value;
    } ise_ctrl_t;

    // what one cell shows to its neighbors
    typedef struct packed {
        logic signed [ISE_DATA_W-1:0] value;
        logic                         valid;
        logic                         cond;   // empty, or holds a value above the new one
    } ise_link_t;

endpackage

// ===== hdl/ise_cell.sv =====
`timescale 1ns / 1ps

module ise_cell
    import ise_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  ise_ctrl_t ctrl,
    input  ise_link_t left,
    input  ise_link_t right,
    output ise_link_t self
);

    logic signed [ISE_DATA_W-1:0] value_reg;
    logic signed [ISE_DATA_W-1:0] value_next;
    logic                         valid_reg;
    logic                         valid_next;
    logic                         gt;

    // strict compare keeps equal values in arrival order
    assign gt = valid_reg && (value_reg > ctrl.new_value);

    assign self.value = value_reg;
    assign self.valid = valid_reg;
    assign self.cond  = !valid_reg || gt;

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.shift_en)
        begin
            value_next = right.value;
            valid_next = right.valid;
        end
        else if (ctrl.insert_en && self.cond)
        begin
            if (left.cond)
            begin
                value_next = left.value;
                valid_next = left.valid;
            end
            else
            begin
                value_next = ctrl.new_value;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// ===== hdl/insertion_sort_engine.sv =====
`timescale 1ns / 1ps

// Stable ascending sort of signed 32-bit values held in a row of cells.
// Input channel (in_valid / in_stall): one value per request, last marks
// the final value of a set. Each accepted value is registered into its cell,
// all cells comparing in parallel, so a set streams in at one per cycle
// while in_stall is low. On the request carrying last, in_stall rises the
// next cycle and the held values drain in ascending order on the output
// channel (out_valid / out_stall), one per cycle while out_stall is low,
// the first in the cycle after last is accepted. final_res marks the last
// value of the set; overflow is set on every value of a set that had more
// than MAX_ITEMS values (extras are dropped). A stalled output holds its
// value; the row shifts only when a request is taken. Input resumes the
// cycle after the final value is taken.
// Reset empties every cell and clears overflow; no clearing pass is needed.

module insertion_sort_engine
    import ise_pkg::*;
#(
    parameter int MAX_ITEMS = ISE_MAX_ITEMS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [ISE_DATA_W-1:0] value,
    input  logic                         last,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [ISE_DATA_W-1:0] sorted_value,
    output logic                         final_res,
    output logic                         overflow
);

    ise_ctrl_t ctrl;
    ise_link_t links [MAX_ITEMS];
    ise_link_t left_in [MAX_ITEMS];
    ise_link_t right_in [MAX_ITEMS];

    logic drain_reg;
    logic drain_next;
    logic drop_reg;
    logic drop_next;
    logic in_take;
    logic out_take;
    logic full;

    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid && !out_stall;
    assign full     = links[MAX_ITEMS-1].valid;

    assign ctrl.insert_en = in_take && !full;
    assign ctrl.shift_en  = out_take;
    assign ctrl.new_value = value;

    genvar i;
    generate
        for (i = 0; i < MAX_ITEMS; i++)
        begin : g_cell
            if (i == 0)
            begin : g_head
                assign left_in[i] = '{value: '0, valid: 1'b0, cond: 1'b0};
            end
            else
            begin : g_mid
                assign left_in[i] = links[i-1];
            end
            if (i == MAX_ITEMS - 1)
            begin : g_tail
                assign right_in[i] = '{value: '0, valid: 1'b0, cond: 1'b0};
            end
            else
            begin : g_body
                assign right_in[i] = links[i+1];
            end

            ise_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (ctrl),
                .left  (left_in[i]),
                .right (right_in[i]),
                .self  (links[i])
            );
        end
    endgenerate

    assign in_stall     = drain_reg;
    assign out_valid    = drain_reg;
    assign sorted_value = links[0].value;
    assign final_res    = !links[1].valid;
    assign overflow     = drop_reg;

    always_comb
    begin
        drain_next = drain_reg;
        drop_next  = drop_reg;
        if (in_take)
        begin
            if (full)
            begin
                drop_next = 1'b1;
            end
            if (last)
            begin
                drain_next = 1'b1;
            end
        end
        if (out_take && final_res)
        begin
            drain_next = 1'b0;
            drop_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_reg <= 1'b0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            drain_reg <= drain_next;
            drop_reg  <= drop_next;
        end
    end

endmodule
